### design/bkm_pkg.sv
package bkm_pkg;

   localparam int WORD_BITS      = 16;
   localparam int FRAC_BITS      = 11;
   localparam int MAX_ITERATIONS = 16;
   localparam int COUNT_BITS     = 5;
   localparam int INDEX_BITS     = 4;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(11);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = COUNT_BITS'(MAX_ITERATIONS);

   // Fixed-point constants, rounded to the nearest value with FRAC_BITS fraction bits.
   localparam logic signed [WORD_BITS-1:0] LIMIT_WORD = 16'sd3199;  // 1.56202
   localparam logic signed [WORD_BITS-1:0] SLOPE_WORD = 16'sd2944;  // 23/16
   localparam logic signed [WORD_BITS-1:0] LN2_WORD   = 16'sd1420;  // ln 2

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MULT   = 5'b00010,
      ST_REDUCE = 5'b00100,
      ST_ITER   = 5'b01000,
      ST_SCALE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic     take;
      word_type l_next;
      word_type e_next;
   } step_type;

   // ln(1 + 2^-i), rounded to the word format.
   function automatic word_type log_entry(input logic [INDEX_BITS-1:0] idx);
      word_type t;
      case (idx)
         4'd0:    t = 16'sd1420;
         4'd1:    t = 16'sd830;
         4'd2:    t = 16'sd457;
         4'd3:    t = 16'sd241;
         4'd4:    t = 16'sd124;
         4'd5:    t = 16'sd63;
         4'd6:    t = 16'sd32;
         4'd7:    t = 16'sd16;
         4'd8:    t = 16'sd8;
         4'd9:    t = 16'sd4;
         4'd10:   t = 16'sd2;
         4'd11:   t = 16'sd1;
         default: t = 16'sd0;
      endcase
      return t;
   endfunction

endpackage

### design/bkm_iter_unit.sv
module bkm_iter_unit (
   input  bkm_pkg::word_type                 l_value,
   input  bkm_pkg::word_type                 e_value,
   input  logic [bkm_pkg::INDEX_BITS-1:0]    index,
   output bkm_pkg::step_type                 step
);

   bkm_pkg::word_type table_value;
   bkm_pkg::word_type e_shifted;

   always_comb begin
      table_value = bkm_pkg::log_entry(index);
      e_shifted   = e_value >>> index;
      step.take   = (l_value > table_value);
      if (step.take) begin
         step.l_next = l_value - table_value;
         step.e_next = e_value + e_shifted;
      end else begin
         step.l_next = l_value;
         step.e_next = e_value;
      end
   end

endmodule

### design/bkm_exponential_unit.sv
// Channel    Ports                                        Transfer
// request    start, busy, req_argument, req_start_value   start high while busy is low
// response   rsp_strobe, rsp_exp_result, rsp_residual     one cycle with rsp_strobe high
// config     csr_write_enable, csr_write_data             any cycle with the enable high
//
// After its transfer an argument passes through the range-reduction multiply, the
// reduction itself, N iterations of the shared compare-and-add unit, where N is the
// iteration count capped at 16, and the final scaling shift, which raises the response
// strobe. Busy is high throughout. The synchronous reset returns the sequencer to idle
// and the iteration count to 11. The receiver cannot stall responses.
module bkm_exponential_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [15:0]                  req_argument,
   input  logic signed [15:0]                  req_start_value,
   output logic                                rsp_strobe,
   output logic signed [15:0]                  rsp_exp_result,
   output logic signed [15:0]                  rsp_residual,
   input  logic                                csr_write_enable,
   input  logic [bkm_pkg::COUNT_BITS-1:0]      csr_write_data
);

   bkm_pkg::state_type state_ff, state_in;
   logic [bkm_pkg::COUNT_BITS-1:0] iteration_count_ff, iteration_count_in;
   logic [bkm_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [bkm_pkg::COUNT_BITS-1:0] idx_ff, idx_in;
   bkm_pkg::word_type x_ff, x_in;
   bkm_pkg::word_type e_ff, e_in;
   bkm_pkg::word_type l_ff, l_in;
   bkm_pkg::word_type prod_ff, prod_in;
   logic reduce_ff, reduce_in;
   logic signed [4:0] shift_ff, shift_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   bkm_pkg::word_type rsp_exp_ff, rsp_exp_in;
   bkm_pkg::word_type rsp_res_ff, rsp_res_in;

   logic signed [2*bkm_pkg::WORD_BITS-1:0] prod_full;
   logic signed [4:0]                      red_shift;
   logic [4:0]                             neg_shift;
   logic [bkm_pkg::COUNT_BITS-1:0]         count_eff;
   bkm_pkg::step_type                      step;

   bkm_iter_unit u_iter (
      .l_value (l_ff),
      .e_value (e_ff),
      .index   (idx_ff[bkm_pkg::INDEX_BITS-1:0]),
      .step    (step)
   );

   always_comb begin
      iteration_count_in = csr_write_enable ? csr_write_data : iteration_count_ff;
      count_eff = (iteration_count_ff > bkm_pkg::COUNT_MAX) ? bkm_pkg::COUNT_MAX
                                                            : iteration_count_ff;

      prod_full = (2*bkm_pkg::WORD_BITS)'(x_ff * bkm_pkg::SLOPE_WORD);
      // Integer part of the scaled argument: the top bits of the wrapped product.
      red_shift = reduce_ff ? prod_ff[bkm_pkg::WORD_BITS-1:bkm_pkg::FRAC_BITS] : 5'sd0;
      neg_shift = 5'(-shift_ff);

      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      x_in          = x_ff;
      e_in          = e_ff;
      l_in          = l_ff;
      prod_in       = prod_ff;
      reduce_in     = reduce_ff;
      shift_in      = shift_ff;
      rsp_strobe_in = 1'b0;
      rsp_exp_in    = rsp_exp_ff;
      rsp_res_in    = rsp_res_ff;

      unique case (state_ff)
         bkm_pkg::ST_IDLE: begin
            if (start) begin
               x_in     = req_argument;
               e_in     = req_start_value;
               count_in = count_eff;
               state_in = bkm_pkg::ST_MULT;
            end
         end
         bkm_pkg::ST_MULT: begin
            prod_in   = prod_full[bkm_pkg::FRAC_BITS+bkm_pkg::WORD_BITS-1:bkm_pkg::FRAC_BITS];
            reduce_in = (x_ff > bkm_pkg::LIMIT_WORD) || (x_ff < 16'sd0);
            state_in  = bkm_pkg::ST_REDUCE;
         end
         bkm_pkg::ST_REDUCE: begin
            shift_in = red_shift;
            l_in     = x_ff - bkm_pkg::WORD_BITS'(red_shift * bkm_pkg::LN2_WORD);
            idx_in   = '0;
            state_in = (count_ff == '0) ? bkm_pkg::ST_SCALE : bkm_pkg::ST_ITER;
         end
         bkm_pkg::ST_ITER: begin
            l_in   = step.l_next;
            e_in   = step.e_next;
            idx_in = idx_ff + 5'd1;
            if (idx_ff + 5'd1 == count_ff) begin
               state_in = bkm_pkg::ST_SCALE;
            end
         end
         bkm_pkg::ST_SCALE: begin
            // A right shift by the full word width leaves only sign bits, as required.
            if (shift_ff > 5'sd0) begin
               rsp_exp_in = e_ff << shift_ff[3:0];
            end else if (shift_ff < 5'sd0) begin
               rsp_exp_in = e_ff >>> neg_shift;
            end else begin
               rsp_exp_in = e_ff;
            end
            rsp_res_in    = l_ff;
            rsp_strobe_in = 1'b1;
            state_in      = bkm_pkg::ST_IDLE;
         end
         default: begin
            state_in = bkm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= bkm_pkg::ST_IDLE;
         iteration_count_ff <= bkm_pkg::COUNT_RESET;
         rsp_strobe_ff      <= 1'b0;
      end else begin
         state_ff           <= state_in;
         iteration_count_ff <= iteration_count_in;
         rsp_strobe_ff      <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      idx_ff     <= idx_in;
      x_ff       <= x_in;
      e_ff       <= e_in;
      l_ff       <= l_in;
      prod_ff    <= prod_in;
      reduce_ff  <= reduce_in;
      shift_ff   <= shift_in;
      rsp_exp_ff <= rsp_exp_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign busy           = (state_ff != bkm_pkg::ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_exp_result = rsp_exp_ff;
   assign rsp_residual   = rsp_res_ff;

endmodule
